FILE: src/sgiu_pkg.sv
`default_nettype none
package sgiu_pkg;

   localparam int CoordWidth = 32;
   localparam int MagWidth   = 32;
   localparam int MassWidth  = 32;
   localparam int HwWidth    = 31;
   localparam int AccWidth   = 48;
   localparam int CsrWidth   = 32;
   localparam int CsrIdxWidth = 2;

   localparam int MulSteps  = 8;
   localparam int SqrtSteps = 41;
   localparam int ProdSteps = 11;
   localparam int DivSteps  = 48;

   localparam logic [31:0] GravityReset   = 32'd65536;
   localparam logic [16:0] AngleReset     = 17'd32768;
   localparam logic [31:0] SofteningReset = 32'd13107;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_GRAVITY   = 2'd0,
      CSR_ANGLE     = 2'd1,
      CSR_SOFTENING = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [31:0] gravity_constant;
      logic [16:0] opening_angle;
      logic [31:0] softening_square;
   } cfg_type;

   // classified source item, distances already formed
   typedef struct packed {
      logic [2:0][MagWidth-1:0] mag;
      logic [2:0]               neg;
      logic [MassWidth-1:0]     mass;
      logic [HwWidth-1:0]       half_width;
      logic                     leaf;
      logic                     skip;
      logic                     last;
   } job_type;

   typedef struct packed {
      logic                open_children;
      logic [AccWidth-1:0] accel_x;
      logic [AccWidth-1:0] accel_y;
      logic [AccWidth-1:0] accel_z;
      logic                accel_valid;
   } result_type;

endpackage
`default_nettype wire

FILE: src/sgiu_channels.sv
`default_nettype none
interface sgiu_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] target_x;
   logic [31:0] target_y;
   logic [31:0] target_z;
   logic [31:0] source_x;
   logic [31:0] source_y;
   logic [31:0] source_z;
   logic [31:0] source_mass;
   logic [30:0] source_half_width;
   logic        source_is_leaf;
   logic        source_is_target;
   logic        last_of_target;

   modport source (output valid, target_x, target_y, target_z, source_x, source_y,
                   source_z, source_mass, source_half_width, source_is_leaf,
                   source_is_target, last_of_target, input ready);
   modport sink (input valid, target_x, target_y, target_z, source_x, source_y,
                 source_z, source_mass, source_half_width, source_is_leaf,
                 source_is_target, last_of_target, output ready);
endinterface

interface sgiu_rsp_if;
   logic        valid;
   logic        ready;
   logic        open_children;
   logic [47:0] accel_x;
   logic [47:0] accel_y;
   logic [47:0] accel_z;
   logic        accel_valid;

   modport source (output valid, open_children, accel_x, accel_y, accel_z, accel_valid,
                   input ready);
   modport sink (input valid, open_children, accel_x, accel_y, accel_z, accel_valid,
                 output ready);
endinterface
`default_nettype wire

FILE: src/sgiu_front.sv
`default_nettype none
module sgiu_front (
   sgiu_req_if.sink         req_ch,
   input  wire logic        q_ready,
   output logic             push,
   output sgiu_pkg::job_type push_job
);

   logic [2:0][31:0] src;
   logic [2:0][31:0] tgt;
   logic [2:0][32:0] diff;
   logic [2:0][32:0] absd;

   assign src = {req_ch.source_z, req_ch.source_y, req_ch.source_x};
   assign tgt = {req_ch.target_z, req_ch.target_y, req_ch.target_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = {src[i][31], src[i]} - {tgt[i][31], tgt[i]};
         absd[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
         push_job.mag[i] = absd[i][31:0];
         push_job.neg[i] = diff[i][32];
      end
      push_job.mass       = req_ch.source_mass;
      push_job.half_width = req_ch.source_half_width;
      push_job.leaf       = req_ch.source_is_leaf;
      // zero mass, or the target body meeting itself
      push_job.skip       = (req_ch.source_mass == '0) ||
                            (req_ch.source_is_leaf && req_ch.source_is_target);
      push_job.last       = req_ch.last_of_target;
   end

   assign req_ch.ready = q_ready;
   assign push         = req_ch.valid && q_ready;

endmodule
`default_nettype wire

FILE: src/sgiu_queue.sv
`default_nettype none
module sgiu_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sgiu_pkg::job_type push_job,
   output logic                   ready,
   output logic                   valid,
   input  wire logic              pop,
   output sgiu_pkg::job_type      pop_job
);

   sgiu_pkg::job_type entry_ff [2];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        count_ff, count_in;

   assign ready   = (count_ff != 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign pop_job = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff ^ push;
      rd_in    = rd_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

FILE: src/sgiu_back.sv
`default_nettype none
module sgiu_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sgiu_pkg::cfg_type cfg,
   input  wire logic              q_valid,
   input  wire sgiu_pkg::job_type q_job,
   output logic                   pop,
   output logic                   out_valid,
   output sgiu_pkg::result_type   out_result,
   input  wire logic              out_ready
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_SQRT = 7'b0000100,
      ST_PROD = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_ACC  = 7'b0100000,
      ST_DONE = 7'b1000000
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [5:0]           step_ff;
   sgiu_pkg::job_type    job_ff;
   logic [65:0]          d2_ff;
   logic [63:0]          wsq_ff;
   logic [33:0]          th2_ff;
   logic [99:0]          rhs_ff;
   logic [63:0]          gm_ff;
   logic [65:0]          r2_ff;
   logic                 open_ff;
   logic [81:0]          rad_ff;
   logic [43:0]          rem_ff;
   logic [40:0]          root_ff;
   logic [106:0]         r3_ff;
   logic [2:0][95:0]     num_ff;
   logic [2:0]           ovf_ff;
   logic [2:0][106:0]    drem_ff;
   logic [2:0][47:0]     low_ff;
   logic [2:0][47:0]     quo_ff;
   logic [2:0][47:0]     sum_ff;
   logic                 out_valid_ff;
   sgiu_pkg::result_type out_ff;

   logic [33:0]          mul_a, mul_b;
   logic [67:0]          prod;
   logic                 crit_lt;
   logic [43:0]          sq_t, sq_trial;
   logic [2:0][107:0]    div_t;
   logic [2:0]           div_ge;
   logic [2:0][46:0]     cmag;
   logic [2:0][47:0]     cval;
   logic [2:0][48:0]     ssum;
   logic [2:0][47:0]     sat;
   logic                 out_free;

   // shared multiplier, operands picked by the sequencer step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         case (step_ff)
            6'd0: begin mul_a = {2'b0, job_ff.mag[0]}; mul_b = {2'b0, job_ff.mag[0]}; end
            6'd1: begin mul_a = {2'b0, job_ff.mag[1]}; mul_b = {2'b0, job_ff.mag[1]}; end
            6'd2: begin mul_a = {2'b0, job_ff.mag[2]}; mul_b = {2'b0, job_ff.mag[2]}; end
            6'd3: begin
               mul_a = {2'b0, job_ff.half_width, 1'b0};
               mul_b = {2'b0, job_ff.half_width, 1'b0};
            end
            6'd4: begin
               mul_a = {17'b0, cfg.opening_angle};
               mul_b = {17'b0, cfg.opening_angle};
            end
            6'd5: begin mul_a = {1'b0, d2_ff[32:0]}; mul_b = th2_ff; end
            6'd6: begin mul_a = {1'b0, d2_ff[65:33]}; mul_b = th2_ff; end
            6'd7: begin mul_a = {2'b0, cfg.gravity_constant}; mul_b = {2'b0, job_ff.mass}; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == ST_PROD) begin
         case (step_ff)
            6'd0: begin mul_a = {1'b0, r2_ff[32:0]}; mul_b = root_ff[33:0]; end
            6'd1: begin mul_a = {1'b0, r2_ff[32:0]}; mul_b = {27'b0, root_ff[40:34]}; end
            6'd2: begin mul_a = {1'b0, r2_ff[65:33]}; mul_b = root_ff[33:0]; end
            6'd3: begin mul_a = {1'b0, r2_ff[65:33]}; mul_b = {27'b0, root_ff[40:34]}; end
            6'd4: begin mul_a = {2'b0, gm_ff[31:0]}; mul_b = {2'b0, job_ff.mag[0]}; end
            6'd5: begin mul_a = {2'b0, gm_ff[63:32]}; mul_b = {2'b0, job_ff.mag[0]}; end
            6'd6: begin mul_a = {2'b0, gm_ff[31:0]}; mul_b = {2'b0, job_ff.mag[1]}; end
            6'd7: begin mul_a = {2'b0, gm_ff[63:32]}; mul_b = {2'b0, job_ff.mag[1]}; end
            6'd8: begin mul_a = {2'b0, gm_ff[31:0]}; mul_b = {2'b0, job_ff.mag[2]}; end
            6'd9: begin mul_a = {2'b0, gm_ff[63:32]}; mul_b = {2'b0, job_ff.mag[2]}; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   assign prod    = mul_a * mul_b;
   assign crit_lt = {4'b0, wsq_ff, 32'b0} < rhs_ff;

   // one root digit per cycle
   assign sq_t     = {rem_ff[41:0], rad_ff[81:80]};
   assign sq_trial = {1'b0, root_ff, 2'b01};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_t[i]  = {drem_ff[i], low_ff[i][47]};
         div_ge[i] = div_t[i] >= {1'b0, r3_ff};
         cmag[i]   = (ovf_ff[i] || quo_ff[i][47]) ? {47{1'b1}} : quo_ff[i][46:0];
         cval[i]   = job_ff.neg[i] ? (48'd0 - {1'b0, cmag[i]}) : {1'b0, cmag[i]};
         ssum[i]   = {sum_ff[i][47], sum_ff[i]} + {cval[i][47], cval[i]};
         if (ssum[i][48] != ssum[i][47]) begin
            sat[i] = ssum[i][48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
         end else begin
            sat[i] = ssum[i][47:0];
         end
      end
   end

   assign out_free  = !out_valid_ff || out_ready;
   assign pop       = (state_ff == ST_IDLE) && q_valid;
   assign out_valid = out_valid_ff;
   assign out_result = out_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (q_valid) state_in = ST_MUL;
         ST_MUL: begin
            if (step_ff == 6'(sgiu_pkg::MulSteps - 1)) begin
               state_in = (!job_ff.skip && (job_ff.leaf || crit_lt)) ? ST_SQRT : ST_DONE;
            end
         end
         ST_SQRT: if (step_ff == 6'(sgiu_pkg::SqrtSteps - 1)) state_in = ST_PROD;
         ST_PROD: begin
            if (step_ff == 6'(sgiu_pkg::ProdSteps - 1)) begin
               state_in = (r3_ff == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV:  if (step_ff == 6'(sgiu_pkg::DivSteps - 1)) state_in = ST_ACC;
         ST_ACC:  state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= (state_in != state_ff) ? 6'd0 : step_ff + 6'd1;
         if (state_ff == ST_ACC) begin
            sum_ff <= sat;
         end
         if (state_ff == ST_DONE && out_free) begin
            out_valid_ff <= 1'b1;
            if (job_ff.last) sum_ff <= '0;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            job_ff  <= q_job;
            open_ff <= 1'b0;
         end
         ST_MUL: begin
            case (step_ff)
               6'd0: d2_ff  <= 66'(prod);
               6'd1: d2_ff  <= d2_ff + 66'(prod);
               6'd2: d2_ff  <= d2_ff + 66'(prod);
               6'd3: wsq_ff <= prod[63:0];
               6'd4: th2_ff <= prod[33:0];
               6'd5: rhs_ff <= 100'(prod);
               6'd6: rhs_ff <= rhs_ff + (100'(prod) << 33);
               6'd7: begin
                  gm_ff   <= prod[63:0];
                  open_ff <= !job_ff.skip && !job_ff.leaf && !crit_lt;
                  r2_ff   <= d2_ff + {34'b0, cfg.softening_square};
                  rad_ff  <= {d2_ff + {34'b0, cfg.softening_square}, 16'b0};
                  rem_ff  <= '0;
                  root_ff <= '0;
               end
               default: ;
            endcase
         end
         ST_SQRT: begin
            rad_ff <= {rad_ff[79:0], 2'b00};
            if (sq_t >= sq_trial) begin
               rem_ff  <= sq_t - sq_trial;
               root_ff <= {root_ff[39:0], 1'b1};
            end else begin
               rem_ff  <= sq_t;
               root_ff <= {root_ff[39:0], 1'b0};
            end
         end
         ST_PROD: begin
            case (step_ff)
               6'd0: r3_ff <= 107'(prod);
               6'd1: r3_ff <= r3_ff + (107'(prod) << 34);
               6'd2: r3_ff <= r3_ff + (107'(prod) << 33);
               6'd3: r3_ff <= r3_ff + (107'(prod) << 67);
               6'd4: num_ff[0] <= 96'(prod);
               6'd5: num_ff[0] <= num_ff[0] + (96'(prod) << 32);
               6'd6: num_ff[1] <= 96'(prod);
               6'd7: num_ff[1] <= num_ff[1] + (96'(prod) << 32);
               6'd8: num_ff[2] <= 96'(prod);
               6'd9: num_ff[2] <= num_ff[2] + (96'(prod) << 32);
               default: begin
                  // quotient above bit 47 only matters as overflow
                  for (int i = 0; i < 3; i++) begin
                     ovf_ff[i]  <= {27'b0, num_ff[i][95:16]} >= r3_ff;
                     drem_ff[i] <= ({27'b0, num_ff[i][95:16]} >= r3_ff) ?
                                   '0 : {27'b0, num_ff[i][95:16]};
                     low_ff[i]  <= {num_ff[i][15:0], 32'b0};
                     quo_ff[i]  <= '0;
                  end
               end
            endcase
         end
         ST_DIV: begin
            for (int i = 0; i < 3; i++) begin
               low_ff[i] <= {low_ff[i][46:0], 1'b0};
               quo_ff[i] <= {quo_ff[i][46:0], div_ge[i]};
               drem_ff[i] <= div_ge[i] ? 107'(div_t[i] - {1'b0, r3_ff}) : div_t[i][106:0];
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_ff.open_children <= open_ff;
               out_ff.accel_valid   <= job_ff.last;
               out_ff.accel_x       <= job_ff.last ? sum_ff[0] : '0;
               out_ff.accel_y       <= job_ff.last ? sum_ff[1] : '0;
               out_ff.accel_z       <= job_ff.last ? sum_ff[2] : '0;
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

FILE: src/softened_gravity_interaction_unit.sv
`default_nettype none
// barnes-hut interaction unit: each req transaction offers one tree node or body
// against one target body; every transaction yields exactly one rsp transaction
// carrying open_children, and on the last source of a target the saturated
// q24.24 acceleration sum (then cleared). a two-deep queue sits between the
// classifying front and the arithmetic back, so req can be taken while the back
// works and a finished result waits in the output register. the back works on
// one source at a time: a skipped source or an opened node takes 8 multiply
// steps on the shared 34x34 multiplier; an applied source then also passes the
// digit-serial square root, the shared multiply steps that form r cubed and the
// numerators, and the bit-serial divider (three axes in parallel).
// csr writes take effect at once and belong to idle periods.
module softened_gravity_interaction_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   sgiu_req_if.sink         req_ch,
   sgiu_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   sgiu_pkg::cfg_type    cfg_ff;
   sgiu_pkg::job_type    push_job, pop_job;
   sgiu_pkg::result_type result;
   logic                 push, pop, q_ready, q_valid;

   // config registers, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity_constant <= sgiu_pkg::GravityReset;
         cfg_ff.opening_angle    <= sgiu_pkg::AngleReset;
         cfg_ff.softening_square <= sgiu_pkg::SofteningReset;
      end else if (csr_we) begin
         case (csr_index)
            sgiu_pkg::CSR_GRAVITY:   cfg_ff.gravity_constant <= csr_wdata;
            sgiu_pkg::CSR_ANGLE:     cfg_ff.opening_angle    <= csr_wdata[16:0];
            sgiu_pkg::CSR_SOFTENING: cfg_ff.softening_square <= csr_wdata;
            default: ;
         endcase
      end
   end

   // distance forming and skip classification
   sgiu_front u_front (
      .req_ch   (req_ch),
      .q_ready  (q_ready),
      .push     (push),
      .push_job (push_job)
   );

   // decoupling queue
   sgiu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .ready    (q_ready),
      .valid    (q_valid),
      .pop      (pop),
      .pop_job  (pop_job)
   );

   // criterion, root, divide and accumulate
   sgiu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_job      (pop_job),
      .pop        (pop),
      .out_valid  (rsp_ch.valid),
      .out_result (result),
      .out_ready  (rsp_ch.ready)
   );

   assign rsp_ch.open_children = result.open_children;
   assign rsp_ch.accel_x       = result.accel_x;
   assign rsp_ch.accel_y       = result.accel_y;
   assign rsp_ch.accel_z       = result.accel_z;
   assign rsp_ch.accel_valid   = result.accel_valid;

`ifndef SYNTHESIS
   // a non-final result carries no acceleration
   a_zero_accel: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.accel_valid) |->
      (rsp_ch.accel_x == '0 && rsp_ch.accel_y == '0 && rsp_ch.accel_z == '0))
      else $error("accel fields nonzero on non-final result");

   // an accepted transaction is visible to the back next cycle
   a_push_seen: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> q_valid)
      else $error("accepted transaction lost before queue");
`endif

endmodule
`default_nettype wire
